>>> src/assert_macros.svh
// assertion macros shared by the stack machine rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SMX_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SMX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/smx_pkg.sv
// package for the stack machine execute block: widths, codes, microcode rom
// no dependencies; used by stack_machine_execute
`default_nettype none

package smx_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int DATA_W      = 30;
  localparam int DEPTH_OUT_W = 9;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;
  localparam int DCNT_W      = 6;

  typedef enum logic [1:0] {
    HDR_POS  = 2'd0,
    HDR_PRIM = 2'd1,
    HDR_NEG  = 2'd2,
    HDR_RSVD = 2'd3
  } hdr_t;

  localparam logic [DATA_W-1:0] PRIM_HALT = 30'd0;
  localparam logic [DATA_W-1:0] PRIM_ADD  = 30'd1;
  localparam logic [DATA_W-1:0] PRIM_SUB  = 30'd2;
  localparam logic [DATA_W-1:0] PRIM_MUL  = 30'd3;
  localparam logic [DATA_W-1:0] PRIM_DIV  = 30'd4;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_HALTED  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    UOP_FETCH,
    UOP_PUSH,
    UOP_EMIT,
    UOP_HALT,
    UOP_READ,
    UOP_ALU,
    UOP_DIVINIT,
    UOP_DIVSTEP,
    UOP_DIVFIX,
    UOP_WB
  } uop_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_DISPATCH,
    J_DIVZERO,
    J_LOOP
  } jcond_t;

  typedef logic [3:0] upc_t;

  localparam upc_t ADR_FETCH   = 4'd0;
  localparam upc_t ADR_PUSH    = 4'd1;
  localparam upc_t ADR_NOP     = 4'd2;
  localparam upc_t ADR_UNDER   = 4'd3;
  localparam upc_t ADR_OVER    = 4'd4;
  localparam upc_t ADR_HALTED  = 4'd5;
  localparam upc_t ADR_HALT    = 4'd6;
  localparam upc_t ADR_ARD     = 4'd7;
  localparam upc_t ADR_ALU     = 4'd8;
  localparam upc_t ADR_DRD     = 4'd9;
  localparam upc_t ADR_DCHK    = 4'd10;
  localparam upc_t ADR_DZ      = 4'd11;
  localparam upc_t ADR_WB      = 4'd12;
  localparam upc_t ADR_DSTEP   = 4'd13;
  localparam upc_t ADR_DFIX    = 4'd14;

  typedef struct packed {
    uop_t    uop;
    jcond_t  jc;
    logic    emit;
    status_t st;
    upc_t    next;
    upc_t    alt;
  } ctl_t;

  function automatic ctl_t ucode_rom(upc_t a);
    ctl_t w;
    unique case (a)
      ADR_FETCH:  w = '{UOP_FETCH,   J_DISPATCH, 1'b0, ST_OK,      ADR_FETCH, ADR_FETCH};
      ADR_PUSH:   w = '{UOP_PUSH,    J_NEXT,     1'b1, ST_OK,      ADR_FETCH, ADR_FETCH};
      ADR_NOP:    w = '{UOP_EMIT,    J_NEXT,     1'b1, ST_OK,      ADR_FETCH, ADR_FETCH};
      ADR_UNDER:  w = '{UOP_EMIT,    J_NEXT,     1'b1, ST_UNDER,   ADR_FETCH, ADR_FETCH};
      ADR_OVER:   w = '{UOP_EMIT,    J_NEXT,     1'b1, ST_OVER,    ADR_FETCH, ADR_FETCH};
      ADR_HALTED: w = '{UOP_EMIT,    J_NEXT,     1'b1, ST_HALTED,  ADR_FETCH, ADR_FETCH};
      ADR_HALT:   w = '{UOP_HALT,    J_NEXT,     1'b1, ST_OK,      ADR_FETCH, ADR_FETCH};
      ADR_ARD:    w = '{UOP_READ,    J_NEXT,     1'b0, ST_OK,      ADR_ALU,   ADR_FETCH};
      ADR_ALU:    w = '{UOP_ALU,     J_NEXT,     1'b0, ST_OK,      ADR_WB,    ADR_FETCH};
      ADR_DRD:    w = '{UOP_READ,    J_NEXT,     1'b0, ST_OK,      ADR_DCHK,  ADR_FETCH};
      ADR_DCHK:   w = '{UOP_DIVINIT, J_DIVZERO,  1'b0, ST_OK,      ADR_DSTEP, ADR_DZ};
      ADR_DZ:     w = '{UOP_EMIT,    J_NEXT,     1'b1, ST_DIVZERO, ADR_FETCH, ADR_FETCH};
      ADR_WB:     w = '{UOP_WB,      J_NEXT,     1'b1, ST_OK,      ADR_FETCH, ADR_FETCH};
      ADR_DSTEP:  w = '{UOP_DIVSTEP, J_LOOP,     1'b0, ST_OK,      ADR_DFIX,  ADR_FETCH};
      ADR_DFIX:   w = '{UOP_DIVFIX,  J_NEXT,     1'b0, ST_OK,      ADR_WB,    ADR_FETCH};
      default:    w = '{UOP_FETCH,   J_DISPATCH, 1'b0, ST_OK,      ADR_FETCH, ADR_FETCH};
    endcase
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] magnitude(logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (WORD_W'(0) - v) : v;
  endfunction

endpackage

`default_nettype wire

>>> src/smx_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/stack_machine_execute.sv
// stack machine execute unit: microcoded sequencer on the smx_pkg rom over an smx_ram stack
// after fetch, push, halt, no-op, underflow, overflow and after-halt items emit directly;
// add/sub/mul read, compute and write back; divide by zero reads, checks and emits;
// div reads, checks, runs a 32-step loop, fixes the sign and writes back; one item in
// flight, and a result held in the output register stalls the sequencer until it is taken
// reset clears stack depth, halt flag, sequencer and output valid; stack ram is not cleared
`default_nettype none

module stack_machine_execute (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [smx_pkg::IN_TDATA_W-1:0]    in_tdata,   // [31:0] instr_word
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] top_value, [40:32] depth_now, [41] halted_flag, [44:42] status, rest 0
  output logic      [smx_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  import smx_pkg::*;

  `include "assert_macros.svh"

  ctl_t              ctl;
  upc_t              upc_r, upc_nxt, disp_adr;
  logic [WORD_W-1:0] instr_r, instr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt, cnt_m2;
  logic [WORD_W-1:0] top_r, top_nxt;
  logic              stopped_r, stopped_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;
  logic [WORD_W:0]   rem_r, rem_nxt, rem_sh, rem_diff;
  logic [WORD_W-1:0] quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              neg_r, neg_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic              accept, stall, emit_go;
  logic [WORD_W-1:0] push_val, top_out, mul_full;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  hdr_t              in_hdr, ex_hdr;
  logic [DATA_W-1:0] in_data, ex_data;

  smx_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ctl       = ucode_rom(upc_r);
  assign in_tready = (ctl.uop == UOP_FETCH);
  assign accept    = in_tvalid & in_tready;
  assign stall     = ctl.emit & out_tvalid_r & ~out_tready;
  assign emit_go   = ctl.emit & ~stall;

  assign in_hdr  = hdr_t'(in_tdata[WORD_W-1 -: 2]);
  assign in_data = in_tdata[DATA_W-1:0];
  assign ex_hdr  = hdr_t'(instr_r[WORD_W-1 -: 2]);
  assign ex_data = instr_r[DATA_W-1:0];

  assign cnt_m2    = count_r - CNT_W'(2);
  assign ram_raddr = cnt_m2[ADDR_W-1:0];
  assign push_val  = (ex_hdr == HDR_NEG) ? (WORD_W'(0) - {2'b00, ex_data})
                                         : {2'b00, ex_data};
  assign mul_full  = ram_rdata * top_r;

  assign rem_sh   = {rem_r[WORD_W-1:0], quo_r[WORD_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};

  // dispatch decode on the incoming instruction and current stack state
  always_comb begin
    disp_adr = ADR_NOP;
    if (stopped_r) begin
      disp_adr = ADR_HALTED;
    end else begin
      unique case (in_hdr)
        HDR_POS, HDR_NEG: begin
          disp_adr = (count_r >= CNT_W'(STACK_DEPTH)) ? ADR_OVER : ADR_PUSH;
        end
        HDR_PRIM: begin
          if (in_data == PRIM_HALT) begin
            disp_adr = ADR_HALT;
          end else if (in_data > PRIM_DIV) begin
            disp_adr = ADR_NOP;
          end else if (count_r < CNT_W'(2)) begin
            disp_adr = ADR_UNDER;
          end else if (in_data == PRIM_DIV) begin
            disp_adr = ADR_DRD;
          end else begin
            disp_adr = ADR_ARD;
          end
        end
        default: disp_adr = ADR_NOP;
      endcase
    end
  end

  always_comb begin
    upc_nxt     = upc_r;
    instr_nxt   = instr_r;
    count_nxt   = count_r;
    top_nxt     = top_r;
    stopped_nxt = stopped_r;
    res_nxt     = res_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    dvs_nxt     = dvs_r;
    dcnt_nxt    = dcnt_r;
    neg_nxt     = neg_r;
    ram_we      = 1'b0;
    ram_waddr   = count_r[ADDR_W-1:0];
    ram_wdata   = push_val;

    unique case (ctl.uop)
      UOP_FETCH: begin
        if (accept) begin
          instr_nxt = in_tdata;
        end
      end
      UOP_PUSH: begin
        if (!stall) begin
          ram_we    = 1'b1;
          top_nxt   = push_val;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      UOP_HALT: begin
        if (!stall) begin
          stopped_nxt = 1'b1;
        end
      end
      UOP_ALU: begin
        case (ex_data)
          PRIM_ADD: res_nxt = ram_rdata + top_r;
          PRIM_SUB: res_nxt = ram_rdata - top_r;
          default:  res_nxt = mul_full;
        endcase
      end
      UOP_DIVINIT: begin
        rem_nxt  = '0;
        quo_nxt  = magnitude(ram_rdata);
        dvs_nxt  = magnitude(top_r);
        dcnt_nxt = DCNT_W'(WORD_W);
        neg_nxt  = ram_rdata[WORD_W-1] ^ top_r[WORD_W-1];
      end
      UOP_DIVSTEP: begin
        // restoring division, one quotient bit per cycle
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (!rem_diff[WORD_W]) begin
          rem_nxt = rem_diff;
          quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
        end
      end
      UOP_DIVFIX: begin
        res_nxt = neg_r ? (WORD_W'(0) - quo_r) : quo_r;
      end
      UOP_WB: begin
        if (!stall) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_m2[ADDR_W-1:0];
          ram_wdata = res_r;
          top_nxt   = res_r;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase

    unique case (ctl.jc)
      J_DISPATCH: upc_nxt = accept ? disp_adr : upc_r;
      J_DIVZERO:  upc_nxt = (top_r == '0) ? ctl.alt : ctl.next;
      J_LOOP:     upc_nxt = (dcnt_r == DCNT_W'(1)) ? ctl.next : upc_r;
      default:    upc_nxt = stall ? upc_r : ctl.next;
    endcase
  end

  // output register, reloaded in the cycle it is taken
  always_comb begin
    top_out        = (count_nxt == '0) ? '0 : top_nxt;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    if (emit_go) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {3'b000, ctl.st, stopped_nxt, DEPTH_OUT_W'(count_nxt), top_out};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r        <= ADR_FETCH;
      count_r      <= '0;
      stopped_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      upc_r        <= upc_nxt;
      count_r      <= count_nxt;
      stopped_r    <= stopped_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    instr_r     <= instr_nxt;
    top_r       <= top_nxt;
    res_r       <= res_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    dvs_r       <= dvs_nxt;
    dcnt_r      <= dcnt_nxt;
    neg_r       <= neg_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `SMX_ASSERT_IMPLY(a_depth_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(STACK_DEPTH),
    "stack depth beyond capacity")
  `SMX_ASSERT_NEXT(a_halt_sticky, clk, rst_n, stopped_r, stopped_r,
    "halt flag cleared without reset")
  `SMX_ASSERT_NEXT(a_count_on_emit, clk, rst_n, !emit_go, $stable(count_r),
    "stack depth changed without a result")
  `SMX_ASSERT_IMPLY(a_loop_count, clk, rst_n, ctl.uop == UOP_DIVSTEP, dcnt_r != '0,
    "divider loop ran past its last step")

endmodule

`default_nettype wire
